// File: rtl/core/bptc_pkg.sv
`default_nettype none

package bptc_pkg;

    localparam int RAW_W   = 24;
    localparam int COEFF_W = 16;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SENS_BASE     = 3'd0,
        REG_OFFSET_BASE   = 3'd1,
        REG_SENS_TEMPCO   = 3'd2,
        REG_OFFSET_TEMPCO = 3'd3,
        REG_REF_TEMP      = 3'd4,
        REG_TEMP_SLOPE    = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [RAW_W-1:0] raw_pressure;
        logic [RAW_W-1:0] raw_temperature;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] pressure_mbar;
        logic signed [11:0] temperature_degc;
    } t_out_word;

    // Offsets of the formula
    localparam logic signed [19:0] TEMP_BASE  = 20'sd2000;
    localparam logic signed [19:0] TEMP_ROUND = 20'sd50;

    // Divide by 100 as multiply-high: K = ceil(2^S / 100), S = N + 7, exact for N-bit m
    localparam int          T_SHIFT = 27;                 // N = 20
    localparam logic [20:0] T_RECIP = 21'd1342178;
    localparam int          P_SHIFT = 34;                 // N = 27
    localparam logic [27:0] P_RECIP = 28'd171798692;

    localparam logic signed [11:0] T_MAX = 12'sd2047;
    localparam logic signed [11:0] T_MIN = -12'sd2048;
    localparam logic signed [15:0] P_MAX = 16'sd32767;
    localparam logic signed [15:0] P_MIN = -16'sd32768;

endpackage

`default_nettype wire

// File: rtl/core/baro_pressure_temp_compensation_unit.sv
// First-order barometer compensation. Each raw pair (D1 pressure, D2 temperature)
// is turned into pressure in mbar and temperature in whole degrees C using the six
// calibration words C1..C6 written through the cfg port (index 0..5, others ignored).
// The datapath is an 8-stage pipeline: one word is accepted per cycle while the output
// is not stalled, and each result leaves in the order its word came in.
// The multiplies set the depth: three 16x26 tempco products, then D1*SENS split in
// two partial products, then two multiply-by-reciprocal divides by 100. When the
// output word is held by a low i_out_ready, the whole pipe stalls in place.
// Calibration words must only change while the pipe is empty.
`default_nettype none

module baro_pressure_temp_compensation_unit
    import bptc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [COEFF_W-1:0]   i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_in_word             i_in_word,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output t_out_word                 o_out_word
);

    localparam int NSTG = 8;

    // calibration registers
    logic [COEFF_W-1:0] r_c1, r_c2, r_c3, r_c4, r_c5, r_c6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1 <= '0;
            r_c2 <= '0;
            r_c3 <= '0;
            r_c4 <= '0;
            r_c5 <= '0;
            r_c6 <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_SENS_BASE:     r_c1 <= i_cfg_data;
                REG_OFFSET_BASE:   r_c2 <= i_cfg_data;
                REG_SENS_TEMPCO:   r_c3 <= i_cfg_data;
                REG_OFFSET_TEMPCO: r_c4 <= i_cfg_data;
                REG_REF_TEMP:      r_c5 <= i_cfg_data;
                REG_TEMP_SLOPE:    r_c6 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline control
    logic            w_adv;
    logic [NSTG:1]   r_vld;

    assign w_adv      = !r_vld[NSTG] || i_out_ready;
    assign o_in_ready = w_adv;
    assign o_out_valid = r_vld[NSTG];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NSTG-1:1], i_in_valid};
        end
    end

    // stage 1: dT
    logic signed [25:0] n_dt, r_dt;
    logic [RAW_W-1:0]   r_d1_s1, r_d1_s2, r_d1_s3;

    assign n_dt = $signed({2'b00, i_in_word.raw_temperature}) - $signed({2'b00, r_c5, 8'h00});

    // stage 2: tempco products
    logic signed [42:0] n_p6, n_p4, n_p3, r_p6, r_p4, r_p3;

    assign n_p6 = $signed({1'b0, r_c6}) * r_dt;
    assign n_p4 = $signed({1'b0, r_c4}) * r_dt;
    assign n_p3 = $signed({1'b0, r_c3}) * r_dt;

    // stage 3: TEMP, OFF, SENS
    logic signed [42:0] w_p6_sh, w_p4_sh, w_p3_sh;
    logic signed [19:0] n_temp, r_temp;
    logic signed [37:0] n_off, r_off_s3, r_off_s4, r_off_s5;
    logic signed [36:0] n_sens, r_sens;

    assign w_p6_sh = r_p6 >>> 23;
    assign w_p4_sh = r_p4 >>> 7;
    assign w_p3_sh = r_p3 >>> 8;
    assign n_temp  = $signed(w_p6_sh[19:0]) + TEMP_BASE;
    assign n_off   = $signed({6'b0, r_c2, 16'b0}) + $signed(w_p4_sh[37:0]);
    assign n_sens  = $signed({6'b0, r_c1, 15'b0}) + $signed(w_p3_sh[36:0]);

    // stage 4: D1*SENS partial products, temperature magnitude
    logic [41:0]        n_plo, r_plo;
    logic signed [43:0] n_phi, r_phi;
    logic signed [19:0] w_tp;
    logic               n_tneg, r_tneg_s4, r_tneg_s5;
    logic [19:0]        n_tmag, r_tmag;

    assign n_plo  = 42'(r_d1_s3) * 42'(r_sens[17:0]);
    assign n_phi  = $signed({1'b0, r_d1_s3}) * $signed(r_sens[36:18]);
    assign w_tp   = r_temp + TEMP_ROUND;
    assign n_tneg = w_tp[19];
    assign n_tmag = n_tneg ? 20'(-w_tp) : 20'(w_tp);

    // stage 5: full product, temperature reciprocal multiply
    logic signed [61:0] w_phi_x, n_full, r_full;
    logic [40:0]        n_tprod, r_tprod;

    assign w_phi_x = 62'(r_phi);
    assign n_full  = (w_phi_x <<< 18) + $signed({20'b0, r_plo});
    assign n_tprod = 41'(r_tmag) * 41'(T_RECIP);

    // stage 6: P before divide, temperature quotient and clamp
    logic signed [61:0] w_full_sh;
    logic signed [41:0] w_diff, w_diff_sh;
    logic signed [26:0] w_p27;
    logic               n_pneg, r_pneg;
    logic [26:0]        n_pmag, r_pmag;
    logic [13:0]        w_tq;
    logic signed [11:0] n_tout, r_tout_s6, r_tout_s7;

    assign w_full_sh = r_full >>> 21;
    assign w_diff    = $signed(w_full_sh[41:0]) - 42'(r_off_s5);
    assign w_diff_sh = w_diff >>> 15;
    assign w_p27     = $signed(w_diff_sh[26:0]);
    assign n_pneg    = w_p27[26];
    assign n_pmag    = n_pneg ? 27'(-w_p27) : 27'(w_p27);
    assign w_tq      = r_tprod[T_SHIFT +: 14];

    always_comb begin
        if (r_tneg_s5) begin
            n_tout = (w_tq > 14'd2048) ? T_MIN : $signed(12'(14'd0 - w_tq));
        end else begin
            n_tout = (w_tq > 14'd2047) ? T_MAX : $signed(w_tq[11:0]);
        end
    end

    // stage 7: pressure reciprocal multiply
    logic [54:0] n_pprod, r_pprod;
    logic        r_pneg_s7;

    assign n_pprod = 55'(r_pmag) * 55'(P_RECIP);

    // stage 8: pressure quotient, clamp, output word
    logic [20:0] w_pq;
    t_out_word   n_out, r_out;

    assign w_pq = r_pprod[P_SHIFT +: 21];

    always_comb begin
        n_out.temperature_degc = r_tout_s7;
        if (r_pneg_s7) begin
            n_out.pressure_mbar = (w_pq > 21'd32768) ? P_MIN : $signed(16'(21'd0 - w_pq));
        end else begin
            n_out.pressure_mbar = (w_pq > 21'd32767) ? P_MAX : $signed(w_pq[15:0]);
        end
    end

    assign o_out_word = r_out;

    // datapath registers, no reset
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dt      <= n_dt;
            r_d1_s1   <= i_in_word.raw_pressure;
            r_p6      <= n_p6;
            r_p4      <= n_p4;
            r_p3      <= n_p3;
            r_d1_s2   <= r_d1_s1;
            r_temp    <= n_temp;
            r_off_s3  <= n_off;
            r_sens    <= n_sens;
            r_d1_s3   <= r_d1_s2;
            r_plo     <= n_plo;
            r_phi     <= n_phi;
            r_tneg_s4 <= n_tneg;
            r_tmag    <= n_tmag;
            r_off_s4  <= r_off_s3;
            r_full    <= n_full;
            r_tprod   <= n_tprod;
            r_tneg_s5 <= r_tneg_s4;
            r_off_s5  <= r_off_s4;
            r_pneg    <= n_pneg;
            r_pmag    <= n_pmag;
            r_tout_s6 <= n_tout;
            r_pprod   <= n_pprod;
            r_pneg_s7 <= r_pneg;
            r_tout_s7 <= r_tout_s6;
            r_out     <= n_out;
        end
    end

    // checks
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_vld))
        else $error("pipeline valid bits moved during a stall");

    a_feed_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_vld[NSTG-1] |=> o_out_valid)
        else $error("word lost at the output stage");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_vld[1])
        else $error("accepted word did not enter the pipeline");

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
    import bptc_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int NUM_CAL         = 6;
    localparam int RAND_PHASES     = 8;
    localparam int WORDS_PER_PHASE = 119;
    localparam int DRAIN_CYCLES    = 16;
    localparam int TIMEOUT_NS      = 5_000_000;

    // indexes past the last calibration word; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam logic [RAW_W-1:0]   RAW_MAX   = '1;
    localparam logic [COEFF_W-1:0] COEFF_MAX = '1;

    typedef enum logic [1:0] {
        ROW_WORD,   // checked against the predictor
        ROW_FIXED,  // result typed in the table
        ROW_CAL,    // load a calibration preset
        ROW_SPARE   // write the unused register indexes
    } t_row_kind;

    typedef struct packed {
        t_row_kind  kind;
        t_in_word   word;
        t_out_word  fixed;
        logic [1:0] preset;
    } t_row;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COEFF_W-1:0]   cfg_data  = '0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_word  in_word   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_word out_word;

    // tb-side copy of the calibration words
    logic [COEFF_W-1:0] cal_words [NUM_CAL];
    logic [COEFF_W-1:0] cal_presets [4][NUM_CAL] = '{
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
        '{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312},
        '{16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
        '{16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h0001}
    };

    t_out_word pending_results [$];
    t_out_word want;
    logic      fixed_en  = 1'b0;
    t_out_word fixed_res = '0;

    int in_idle_pct   = 0;
    int out_stall_pct = 0;
    int words_sent    = 0;
    int results_seen  = 0;
    int cal_loads     = 0;
    int mismatches    = 0;

    t_row dir_rows [25];

    baro_pressure_temp_compensation_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("status: fail");
        $finish;
    end

    // first-order compensation of one raw pair with the current calibration
    function automatic t_out_word compensate(input t_in_word w);
        longint d1, d2, c1, c2, c3, c4, c5, c6;
        longint dt, temp, off, sens, p, t;
        t_out_word r;
        d1 = longint'(w.raw_pressure);
        d2 = longint'(w.raw_temperature);
        c1 = longint'(cal_words[REG_SENS_BASE]);
        c2 = longint'(cal_words[REG_OFFSET_BASE]);
        c3 = longint'(cal_words[REG_SENS_TEMPCO]);
        c4 = longint'(cal_words[REG_OFFSET_TEMPCO]);
        c5 = longint'(cal_words[REG_REF_TEMP]);
        c6 = longint'(cal_words[REG_TEMP_SLOPE]);
        dt   = d2 - (c5 << 8);
        temp = longint'(TEMP_BASE) + ((c6 * dt) >>> 23);
        off  = (c2 << 16) + ((c4 * dt) >>> 7);
        sens = (c1 << 15) + ((c3 * dt) >>> 8);
        // >>> floors, / truncates toward zero
        p = ((((d1 * sens) >>> 21) - off) >>> 15) / 100;
        t = (temp + longint'(TEMP_ROUND)) / 100;
        if (p > longint'(P_MAX)) begin
            p = longint'(P_MAX);
        end else if (p < longint'(P_MIN)) begin
            p = longint'(P_MIN);
        end
        if (t > longint'(T_MAX)) begin
            t = longint'(T_MAX);
        end else if (t < longint'(T_MIN)) begin
            t = longint'(T_MIN);
        end
        r.pressure_mbar    = p[15:0];
        r.temperature_degc = t[11:0];
        return r;
    endfunction

    function automatic t_row row(input t_row_kind k, input logic [RAW_W-1:0] d1 = '0,
                                 input logic [RAW_W-1:0] d2 = '0,
                                 input logic signed [15:0] p = '0,
                                 input logic signed [11:0] t = '0,
                                 input logic [1:0] set = '0);
        t_row r;
        r.kind                   = k;
        r.word.raw_pressure      = d1;
        r.word.raw_temperature   = d2;
        r.fixed.pressure_mbar    = p;
        r.fixed.temperature_degc = t;
        r.preset                 = set;
        return r;
    endfunction

    function automatic logic [COEFF_W-1:0] pick_coeff();
        case ($urandom_range(3))
            0:       return '0;
            1:       return COEFF_MAX;
            default: return COEFF_W'($urandom);
        endcase
    endfunction

    function automatic logic [RAW_W-1:0] pick_raw_pressure();
        case ($urandom_range(7))
            0:       return '0;
            1:       return RAW_MAX;
            default: return RAW_W'($urandom);
        endcase
    endfunction

    // bias D2 toward C5*256 so small dT of both signs shows up
    function automatic logic [RAW_W-1:0] pick_raw_temperature();
        int near;
        case ($urandom_range(7))
            0:    return '0;
            1:    return RAW_MAX;
            2, 3: begin
                near = int'(cal_words[REG_REF_TEMP]) * 256 + int'($urandom_range(4096)) - 2048;
                if (near < 0) begin
                    return '0;
                end else if (near > int'(RAW_MAX)) begin
                    return RAW_MAX;
                end
                return RAW_W'(near);
            end
            default: return RAW_W'($urandom);
        endcase
    endfunction

    // receiver side: random stall, expectation bookkeeping, result check
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= out_stall_pct);
        if (!rst_n) begin
            foreach (cal_words[i]) cal_words[i] = '0;
        end else begin
            if (cfg_we && cfg_index < NUM_CAL) begin
                cal_words[cfg_index] = cfg_data;
            end
            if (in_valid && in_ready) begin
                pending_results.push_back(fixed_en ? fixed_res : compensate(in_word));
            end
            if (out_valid && out_ready) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: expected no word, got pressure %0d temperature %0d", $time,
                             out_word.pressure_mbar, out_word.temperature_degc);
                end else begin
                    want = pending_results.pop_front();
                    if (out_word.pressure_mbar !== want.pressure_mbar) begin
                        mismatches++;
                        $display("%0t: pressure_mbar expected %0d, got %0d", $time,
                                 want.pressure_mbar, out_word.pressure_mbar);
                    end
                    if (out_word.temperature_degc !== want.temperature_degc) begin
                        mismatches++;
                        $display("%0t: temperature_degc expected %0d, got %0d", $time,
                                 want.temperature_degc, out_word.temperature_degc);
                    end
                end
            end
        end
    end

    task automatic send_word(input t_in_word w, input logic use_fixed, input t_out_word res);
        while ($urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_word   <= w;
        fixed_en  <= use_fixed;
        fixed_res <= res;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        words_sent++;
    endtask

    // hold the sender until every result is back and the pipe has emptied
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEFF_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic load_cal(input logic [COEFF_W-1:0] vals [NUM_CAL], input bit with_spares);
        for (int j = 0; j < NUM_CAL; j++) begin
            write_reg(CFG_IDX_W'(j), vals[j]);
        end
        if (with_spares) begin
            write_reg(REG_SPARE_LO, COEFF_W'($urandom));
            write_reg(REG_SPARE_HI, COEFF_W'($urandom));
        end
        cfg_we <= 1'b0;
        cal_loads++;
    endtask

    initial begin
        t_row               r;
        t_in_word           w;
        logic [COEFF_W-1:0] vals [NUM_CAL];

        // calibration is all zero out of reset: P = 0, T = 2050/100 = 20 for any word
        dir_rows = '{
            row(ROW_FIXED, 24'h000000, 24'h000000, 16'sd0, 12'sd20),
            row(ROW_FIXED, 24'hFFFFFF, 24'hFFFFFF, 16'sd0, 12'sd20),
            row(ROW_FIXED, 24'h800000, 24'h7FFFFF, 16'sd0, 12'sd20),
            row(ROW_SPARE),
            row(ROW_FIXED, 24'hAAAAAA, 24'h555555, 16'sd0, 12'sd20),
            row(ROW_CAL, .set(2'd0)),
            row(ROW_WORD, 24'h000000, 24'h000000),
            row(ROW_WORD, 24'hFFFFFF, 24'hFFFFFF),
            row(ROW_WORD, 24'h000000, 24'hFFFFFF),
            row(ROW_WORD, 24'hFFFFFF, 24'h000000),
            row(ROW_WORD, 24'hFFFFFF, 24'hFFFF00),
            row(ROW_WORD, 24'h7FFFFF, 24'hFFFEFF),
            // sensor datasheet example: 1000 mbar, 20 C
            row(ROW_CAL, .set(2'd1)),
            row(ROW_FIXED, 24'h8AA21A, 24'h82C13E, 16'sd1000, 12'sd20),
            row(ROW_WORD, 24'h8AA21A, 24'h000000),
            row(ROW_WORD, 24'h000000, 24'hFFFFFF),
            row(ROW_WORD, 24'hFFFFFF, 24'h82C13E),
            // negative sensitivity and offset at the coldest reading
            row(ROW_CAL, .set(2'd2)),
            row(ROW_WORD, 24'hFFFFFF, 24'h000000),
            row(ROW_WORD, 24'h000000, 24'h000000),
            row(ROW_WORD, 24'hFFFFFF, 24'hFFFFFF),
            row(ROW_WORD, 24'h123456, 24'hFFFF01),
            row(ROW_CAL, .set(2'd3)),
            row(ROW_WORD, 24'hFFFFFF, 24'hFFFFFF),
            row(ROW_WORD, 24'h000001, 24'h000000)
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i]) begin
            r = dir_rows[i];
            case (r.kind)
                ROW_CAL: begin
                    wait_idle();
                    load_cal(cal_presets[r.preset], 1'b0);
                end
                ROW_SPARE: begin
                    wait_idle();
                    write_reg(REG_SPARE_LO, COEFF_MAX);
                    write_reg(REG_SPARE_HI, COEFF_MAX);
                    cfg_we <= 1'b0;
                end
                ROW_FIXED: send_word(r.word, 1'b1, r.fixed);
                default:   send_word(r.word, 1'b0, r.fixed);
            endcase
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_idle();
            foreach (vals[j]) vals[j] = pick_coeff();
            load_cal(vals, bit'($urandom_range(1)));
            case (ph % 4)
                0: begin in_idle_pct <= 0;  out_stall_pct <= 0;  end
                1: begin in_idle_pct <= 47; out_stall_pct <= 0;  end
                2: begin in_idle_pct <= 0;  out_stall_pct <= 47; end
                default: begin in_idle_pct <= 31; out_stall_pct <= 31; end
            endcase
            repeat (WORDS_PER_PHASE) begin
                w.raw_pressure    = pick_raw_pressure();
                w.raw_temperature = pick_raw_temperature();
                send_word(w, 1'b0, '0);
            end
        end
        wait_idle();

        $display("%0d raw pairs sent under %0d calibration loads, %0d words checked,",
                 words_sent, cal_loads, results_seen);
        $display("idle and stall mixes on both sides; %0d field mismatches", mismatches);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
